@@ design/mshr_pkg.sv @@
// Shared types, sizes and codes of the miss status holding table.
package mshr_pkg;

  localparam int Entries = 8;
  localparam int Slots   = 4;
  localparam int TagBits = 8;
  localparam int EntW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int SlotW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [2:0] OffsetReset = 3'd5;

  typedef enum logic [2:0] {
    StAccepted      = 3'd0,
    StNoEntry       = 3'd1,
    StNoSubentry    = 3'd2,
    StDownBusy      = 3'd3,
    StReleased      = 3'd4,
    StFillUnmatched = 3'd5
  } status_e;

  typedef enum logic {
    BkIdle  = 1'b0,
    BkDrain = 1'b1
  } back_state_e;

  // Classified word handed from front to back.
  typedef struct packed {
    logic              fill;
    logic [31:0]       blk;
    logic [TagBits-1:0] tag;
    logic              down_ready;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic        issue_fetch;
    logic [31:0] fetch_address;
    logic [7:0]  released_tag;
    logic        last;
  } res_t;

endpackage

@@ design/miss_status_holding_table.sv @@
// Top level of the miss status holding table.
// Input words (miss or fill) are pushed with push while full is low; results
// are read with pop while empty is low, oldest first, each on its own ports.
// A miss gives one result word; a matched fill gives one release word per
// waiting tag in ascending slot order, the final one marked by last_o; an
// unmatched fill gives one error word. The block offset register is written
// through cfg_we_i / cfg_wdata_i; the user must do so only while the block is
// idle, as the block does not enforce this. Throughput: the table engine
// handles one miss per cycle while the result queue has room and no fill is
// draining; a fill takes a lookup step, then one release step per waiter, set
// by the single slot read port of the drain sequencer. A two-deep command
// queue and a two-deep result queue sit on either side of the engine; a fill
// enters the drain state before its release words reach the result queue.
// When the receiver stalls, the result queue fills, the engine holds, then
// the command queue fills and full rises. Reset empties both queues, frees
// every entry and slot and sets the block offset to 32-byte blocks; no
// clearing pass is needed.
module miss_status_holding_table import mshr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  waiter_tag_i,
  input  logic        downstream_ready_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic        issue_fetch_o,
  output logic [31:0] fetch_address_o,
  output logic [7:0]  released_tag_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i
);

  logic cmd_valid, cmd_pop, res_we, res_full;
  cmd_t cmd;
  res_t res, head;

  mshr_front u_front (
    .clk_i, .rst_ni, .push, .full, .action_i, .address_i, .waiter_tag_i,
    .downstream_ready_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mshr_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_we_o    (res_we),
    .res_o       (res)
  );

  mshr_outq u_outq (
    .clk_i, .rst_ni,
    .we_i    (res_we),
    .res_i   (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  assign status_o        = head.status;
  assign issue_fetch_o   = head.issue_fetch;
  assign fetch_address_o = head.fetch_address;
  assign released_tag_o  = head.released_tag;
  assign last_o          = head.last;

endmodule

@@ design/mshr_front.sv @@
// Front end: takes input words, aligns the address, queues commands for the back end.
module mshr_front import mshr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  waiter_tag_i,
  input  logic        downstream_ready_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  logic [2:0]  offset_q;
  cmd_t        buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        do_push, do_pop;
  cmd_t        cmd_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cmd_in.fill       = action_i;
    cmd_in.blk        = address_i & (32'hFFFF_FFFF << offset_q);
    cmd_in.tag        = TagBits'(waiter_tag_i);
    cmd_in.down_ready = downstream_ready_i;
  end

  assign full        = (count_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (count_q != 2'd0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ design/mshr_back.sv @@
// Back end: entry and slot table, miss allocation and fill drain sequencer.
module mshr_back import mshr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_we_o,
  output res_t res_o
);

  back_state_e state_q, state_d;

  logic [Entries-1:0] entry_valid_q;
  logic [Entries-1:0] entry_issued_q;
  logic [31:0]        entry_blk_q [Entries];
  logic [Slots-1:0]   slot_valid_q [Entries];
  logic [TagBits-1:0] slot_tag_q [Entries][Slots];
  logic [EntW-1:0]    drain_idx_q;

  logic               hit, any_free, slot_free, last_out;
  logic [EntW-1:0]    hit_idx, free_idx, sel_e;
  logic [SlotW-1:0]   sel_s, drain_s;
  logic [Slots-1:0]   pend, rest;
  status_e            miss_status;
  logic               miss_fetch;
  logic               upd_miss, drain_start, drain_step;

  // Parallel lookup: matching entry and lowest free entry.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < Entries; i++) begin
      if (!hit && entry_valid_q[i] && entry_blk_q[i] == cmd_i.blk) begin
        hit     = 1'b1;
        hit_idx = EntW'(i);
      end
      if (!any_free && !entry_valid_q[i]) begin
        any_free = 1'b1;
        free_idx = EntW'(i);
      end
    end
  end

  always_comb begin
    sel_e     = hit ? hit_idx : free_idx;
    slot_free = 1'b0;
    sel_s     = '0;
    for (int s = 0; s < Slots; s++) begin
      if (!slot_free && !slot_valid_q[sel_e][s]) begin
        slot_free = 1'b1;
        sel_s     = SlotW'(s);
      end
    end
    miss_fetch = 1'b0;
    if (!hit && !any_free) begin
      miss_status = StNoEntry;
    end else if (!slot_free) begin
      miss_status = StNoSubentry;
    end else if (!entry_issued_q[sel_e] && !cmd_i.down_ready) begin
      miss_status = StDownBusy;
    end else begin
      miss_status = StAccepted;
      miss_fetch  = !entry_issued_q[sel_e];
    end
  end

  // Lowest pending waiter of the entry being drained.
  always_comb begin
    pend    = slot_valid_q[drain_idx_q];
    drain_s = '0;
    for (int s = Slots - 1; s >= 0; s--) begin
      if (pend[s]) drain_s = SlotW'(s);
    end
    rest     = pend & ~(Slots'(1) << drain_s);
    last_out = (rest == '0);
  end

  always_comb begin
    state_d     = state_q;
    cmd_pop_o   = 1'b0;
    res_we_o    = 1'b0;
    res_o       = '0;
    res_o.status = StAccepted;
    upd_miss    = 1'b0;
    drain_start = 1'b0;
    drain_step  = 1'b0;
    case (state_q)
      BkIdle: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o  = 1'b1;
          res_o.last = 1'b1;
          if (!cmd_i.fill) begin
            res_we_o            = 1'b1;
            res_o.status        = miss_status;
            res_o.issue_fetch   = miss_fetch;
            res_o.fetch_address = miss_fetch ? cmd_i.blk : 32'd0;
            upd_miss            = (miss_status == StAccepted);
          end else if (hit) begin
            drain_start = 1'b1;
            state_d     = BkDrain;
          end else begin
            res_we_o     = 1'b1;
            res_o.status = StFillUnmatched;
          end
        end
      end
      BkDrain: begin
        if (!res_full_i) begin
          res_we_o     = 1'b1;
          drain_step   = 1'b1;
          res_o.status = StReleased;
          res_o.released_tag = (pend != '0) ? 8'(slot_tag_q[drain_idx_q][drain_s]) : 8'd0;
          res_o.last   = last_out;
          if (last_out) state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q  <= '0;
      entry_issued_q <= '0;
      drain_idx_q    <= '0;
      for (int i = 0; i < Entries; i++) slot_valid_q[i] <= '0;
    end else begin
      if (upd_miss) begin
        entry_valid_q[sel_e]       <= 1'b1;
        entry_issued_q[sel_e]      <= 1'b1;
        slot_valid_q[sel_e][sel_s] <= 1'b1;
      end
      if (drain_start) drain_idx_q <= hit_idx;
      if (drain_step) begin
        slot_valid_q[drain_idx_q][drain_s] <= 1'b0;
        if (last_out) begin
          entry_valid_q[drain_idx_q]  <= 1'b0;
          entry_issued_q[drain_idx_q] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_miss) begin
      entry_blk_q[sel_e]       <= cmd_i.blk;
      slot_tag_q[sel_e][sel_s] <= cmd_i.tag;
    end
  end

  a_drain_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkDrain |-> entry_valid_q[drain_idx_q])
    else $error("draining an entry that is not valid");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == BkIdle)
    else $error("command taken while draining");

  a_fetch_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we_o && res_o.issue_fetch |-> res_o.status == StAccepted && !cmd_i.fill)
    else $error("fetch issued on a result that is not an accepted miss");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkDrain && res_we_o && res_o.last |=>
      state_q == BkIdle && !entry_valid_q[$past(drain_idx_q)])
    else $error("entry not freed after final release");

endmodule

@@ design/mshr_outq.sv @@
// Result queue: two-deep buffer between the back end and the result port.
module mshr_outq import mshr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic we_i,
  input  res_t res_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t head_o
);

  res_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = we_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ sim/miss_status_holding_table_tb.sv @@
// Self-checking testbench of the miss status holding table with a built-in table predictor.
`timescale 1ns / 1ps

module miss_status_holding_table_tb import mshr_pkg::*; ();

  localparam int CycleLimit = 400000;
  localparam int PoolSize   = 10;

  typedef struct packed {
    logic        fill;
    logic [31:0] addr;
    logic [7:0]  tag;
    logic        ready;
  } req_word_t;

  logic        clk;
  logic        rst_ni;
  logic        push = 1'b0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status_o;
  logic        issue_fetch_o;
  logic [31:0] fetch_address_o;
  logic [7:0]  released_tag_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = '0;
  req_word_t   offered = '0;

  miss_status_holding_table dut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .action_i           (offered.fill),
    .address_i          (offered.addr),
    .waiter_tag_i       (offered.tag),
    .downstream_ready_i (offered.ready),
    .empty              (empty),
    .pop                (pop),
    .status_o           (status_o),
    .issue_fetch_o      (issue_fetch_o),
    .fetch_address_o    (fetch_address_o),
    .released_tag_o     (released_tag_o),
    .last_o             (last_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  // Table predictor state
  logic [2:0]         offset_bits = OffsetReset;
  logic               ent_valid  [Entries];
  logic               ent_issued [Entries];
  logic [31:0]        ent_blk    [Entries];
  logic               slot_v     [Entries][Slots];
  logic [TagBits-1:0] slot_t     [Entries][Slots];

  req_word_t   pending_words[$];
  res_t        awaited_results[$];
  int          words_queued   = 0;
  int          words_accepted = 0;
  int          mismatches     = 0;
  int          cycle_count    = 0;
  logic        word_taken     = 1'b0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  logic        next_push;
  logic [15:0] pop_pattern    = '1;
  int          pattern_age    = 0;
  logic        hold_off       = 1'b0;
  logic [31:0] block_pool [PoolSize];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int match_entry(input logic [31:0] blk);
    for (int i = 0; i < Entries; i++)
      if (ent_valid[i] && ent_blk[i] == blk) return i;
    return -1;
  endfunction

  // Append one predicted result word.
  task automatic await_result(input res_t r);
    awaited_results = {awaited_results, r};
  endtask

  // Update the table for one accepted word and queue the results it causes.
  task automatic apply_word(input req_word_t w);
    logic [31:0] blk;
    res_t        r;
    int          e, s, n, k, i;
    blk = w.addr & ~((32'd1 << offset_bits) - 32'd1);
    r = '0;
    r.last = 1'b1;
    e = match_entry(blk);
    if (!w.fill) begin
      if (e < 0)
        for (i = Entries - 1; i >= 0; i--) if (!ent_valid[i]) e = i;
      s = -1;
      if (e >= 0)
        for (i = Slots - 1; i >= 0; i--) if (!slot_v[e][i]) s = i;
      if (e < 0) r.status = StNoEntry;
      else if (s < 0) r.status = StNoSubentry;
      else if (!ent_issued[e] && !w.ready) r.status = StDownBusy;
      else begin
        r.status = StAccepted;
        if (!ent_issued[e]) begin
          r.issue_fetch   = 1'b1;
          r.fetch_address = blk;
          ent_issued[e]   = 1'b1;
        end
        ent_blk[e]    = blk;
        slot_t[e][s]  = w.tag[TagBits-1:0];
        slot_v[e][s]  = 1'b1;
        ent_valid[e]  = 1'b1;
      end
      await_result(r);
    end else if (e < 0) begin
      r.status = StFillUnmatched;
      await_result(r);
    end else begin
      n = 0;
      for (i = 0; i < Slots; i++) if (slot_v[e][i]) n++;
      r.status = StReleased;
      k = 0;
      for (i = 0; i < Slots; i++) begin
        if (slot_v[e][i]) begin
          k++;
          r.released_tag = 8'(slot_t[e][i]);
          r.last         = (k == n);
          await_result(r);
          slot_v[e][i] = 1'b0;
        end
      end
      // Entry without waiters: one bare release word
      if (n == 0) await_result(r);
      ent_valid[e]  = 1'b0;
      ent_issued[e] = 1'b0;
      ent_blk[e]    = '0;
    end
  endtask

  task automatic queue_word(input logic fill, input logic [31:0] addr,
                            input logic [7:0] tag, input logic ready);
    req_word_t w;
    w.fill  = fill;
    w.addr  = addr;
    w.tag   = tag;
    w.ready = ready;
    pending_words = {pending_words, w};
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || awaited_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_offset(input logic [2:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk);
    cfg_we_i    <= 1'b0;
    offset_bits = value;
  endtask

  // Mostly misses and fills on a small pool of blocks so entries and slots run out.
  task automatic queue_random_words(input int count);
    logic [31:0] mask;
    int          pick;
    mask = (32'd1 << offset_bits) - 32'd1;
    for (int i = 0; i < PoolSize; i++) block_pool[i] = $urandom & ~mask;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)
        queue_word(1'b0, block_pool[$urandom_range(0, PoolSize - 1)] | ($urandom & mask),
                   8'($urandom), $urandom_range(0, 99) < 85);
      else if (pick < 90)
        queue_word(1'b1, block_pool[$urandom_range(0, PoolSize - 1)] | ($urandom & mask),
                   8'($urandom), 1'($urandom));
      else
        queue_word(1'($urandom), $urandom, 8'($urandom), 1'($urandom));
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    next_push = push;
    if (!rst_ni) next_push = 1'b0;
    else if (!(push && !word_taken)) begin
      next_push = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (pending_words.size() > 0) begin
        offered   <= pending_words.pop_front();
        next_push = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else burst_left--;
      end
    end
    push <= next_push;
  end

  // Receiver: rotating stall pattern, re-drawn each time its age counter runs out.
  always @(negedge clk) begin
    if (!rst_ni) pop <= 1'b0;
    else begin
      if (pattern_age == 0) begin
        pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
        pattern_age = 64;
      end
      pattern_age--;
      pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
      pop <= !hold_off && pop_pattern[0];
    end
  end

  // Long receiver hold-off while the sender keeps offering, to back up the block.
  initial begin
    @(posedge rst_ni);
    while (words_accepted < 60) @(negedge clk);
    hold_off <= 1'b1;
    repeat (120) @(negedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    word_taken = rst_ni && push && !full;
    if (word_taken) begin
      apply_word(offered);
      words_accepted++;
    end
    if (rst_ni && pop && !empty) begin
      if (awaited_results.size() == 0)
        report_mismatch("word with nothing awaited, status", 32'(status_o), '0);
      else begin
        res_t want;
        want = awaited_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (issue_fetch_o !== want.issue_fetch)
          report_mismatch("issue_fetch", 32'(issue_fetch_o), 32'(want.issue_fetch));
        if (fetch_address_o !== want.fetch_address)
          report_mismatch("fetch_address", fetch_address_o, want.fetch_address);
        if (released_tag_o !== want.released_tag)
          report_mismatch("released_tag", 32'(released_tag_o), 32'(want.released_tag));
        if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
      end
    end
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("miss_status_holding_table: mismatch");
      $finish;
    end
  end

  initial begin
    logic [2:0] offsets [8];
    offsets = '{3'd7, 3'd0, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd5};
    for (int i = 0; i < Entries; i++) begin
      ent_valid[i]  = 1'b0;
      ent_issued[i] = 1'b0;
      ent_blk[i]    = '0;
      for (int j = 0; j < Slots; j++) slot_v[i][j] = 1'b0;
    end
    rst_ni = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed: extremes, reuse, full slots, busy downstream, unmatched fill
    queue_word(1'b0, 32'h0000_0000, 8'h00, 1'b1);
    queue_word(1'b0, 32'hffff_ffff, 8'hff, 1'b1);
    queue_word(1'b0, 32'h0000_001f, 8'ha5, 1'b0);
    queue_word(1'b0, 32'h1000_0000, 8'h77, 1'b0);
    queue_word(1'b1, 32'h1000_0000, 8'h00, 1'b1);
    queue_word(1'b0, 32'h0000_0004, 8'h5a, 1'b1);
    queue_word(1'b0, 32'h0000_0008, 8'h3c, 1'b0);
    queue_word(1'b0, 32'h0000_0010, 8'h11, 1'b1);
    queue_word(1'b1, 32'h0000_0000, 8'hff, 1'b0);
    queue_word(1'b1, 32'hffff_ffe0, 8'h00, 1'b1);
    // Fill every entry, then one more block
    for (int k = 1; k <= Entries; k++) queue_word(1'b0, 32'(k) << 8, 8'(k), 1'b1);
    queue_word(1'b0, 32'h0000_2000, 8'h99, 1'b0);
    for (int k = 1; k <= Entries; k++) queue_word(1'b1, (32'(k) << 8) | 32'h1f, 8'h00, 1'b1);
    wait_drained();

    foreach (offsets[p]) begin
      write_offset(offsets[p]);
      queue_random_words(62);
      wait_drained();
      // Drain what is still outstanding before the block size changes
      for (int i = 0; i < Entries; i++)
        if (ent_valid[i]) queue_word(1'b1, ent_blk[i], 8'($urandom), 1'($urandom));
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", '0, 32'(awaited_results.size()));
    if (mismatches == 0) $display("miss_status_holding_table: match");
    else $display("miss_status_holding_table: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
design/mshr_pkg.sv
design/mshr_front.sv
design/mshr_back.sv
design/mshr_outq.sv
design/miss_status_holding_table.sv
sim/miss_status_holding_table_tb.sv
